// ===== rtl/signed_distance_field_sampler_macros.svh =====
// assertion macros for the signed distance field sampler
`ifndef SIGNED_DISTANCE_FIELD_SAMPLER_MACROS_SVH
`define SIGNED_DISTANCE_FIELD_SAMPLER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SDFS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SDFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sdfs_pkg.sv =====
// shared constants, types and the code threshold table for the sampler
package sdfs_pkg;

    localparam int unsigned MAX_SRC_SIDE_DEF  = 256;
    localparam int unsigned OUT_WIDTH_DEF     = 64;
    localparam int unsigned OUT_HEIGHT_DEF    = 64;
    localparam int unsigned SEARCH_RADIUS_DEF = 512;

    // widest memory word is 2**CHUNK_MAX_LOG bits
    localparam int unsigned CHUNK_MAX_LOG = 6;

    localparam int unsigned CODE_SCALE_SQ = 65025;
    localparam int unsigned KW            = 7;
    localparam int unsigned TW            = 40;
    localparam int unsigned CFG_DW        = 9;

    localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD  = 2'd2;

    typedef logic [TW-1:0] t_thr_tab [0:(1<<KW)-1];

    // entry k holds (k*radius)^2, the smallest scaled square giving code k
    function automatic t_thr_tab thr_table(input int unsigned radius);
        t_thr_tab        t;
        longint unsigned v;
        for (int k = 0; k < (1 << KW); k++) begin
            v    = longint'(k) * longint'(radius);
            t[k] = TW'(v * v);
        end
        return t;
    endfunction

endpackage

// ===== rtl/sdfs_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
module sdfs_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sdfs_div.sv =====
// divider by a constant through reciprocal multiplication, quotient registered
module sdfs_div #(
    parameter int unsigned NW  = 17,
    parameter int unsigned DEN = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    // exact for every numerator below 2**NW
    localparam int unsigned     LD    = $clog2(DEN);
    localparam int unsigned     SH    = NW + LD;
    localparam int unsigned     MW    = SH + 1;
    localparam longint unsigned RECIP = ((longint'(1) << SH) + longint'(DEN) - longint'(1))
                                        / longint'(DEN);

    logic [NW+MW-1:0] prod;
    logic [NW-1:0]    r_quo;
    logic             r_done;

    assign prod = (NW+MW)'(i_num) * (NW+MW)'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_quo  <= '0;
        end else begin
            r_done <= i_start;
            if (i_start) begin
                r_quo <= prod[SH +: NW];
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/signed_distance_field_sampler.sv =====
// signed distance field sampler: inside-mask store and brute-force nearest search
//
// Input channel (i_valid / o_stall): req_type 0 stores one source pixel as an
// inside bit (value above the threshold), req_type 1 queries an output cell.
// Output channel (o_valid / i_stall): one distance code per query, none per write.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready): index 0 source
// width, 1 source height, 2 inside threshold; write only while the block is idle.
// A write reads, modifies and writes back one mask word.
// A query scans h rows of NCH = MAX_SRC_SIDE/CW words per row, rounded up, where
// CW is the mask word width (64 at the default 256 x 256 image). The scan reads
// one CW-bit mask word a cycle, so the memory read port sets the rate.
// The mapped source cell comes from a reciprocal multiplication by the output size,
// the code from a 7-step search of a constant threshold table.
// One item is worked on at a time; o_stall is high while an item is in work.
// A finished result sits in an output register, so a new item is taken while
// the receiver stalls; a further result then waits until that register drains.
// Reset (synchronous, active low) restores the register defaults and clears
// control state; the mask memory is not cleared and must be written before use.
`include "signed_distance_field_sampler_macros.svh"

module signed_distance_field_sampler
    import sdfs_pkg::*;
#(
    parameter int unsigned MAX_SRC_SIDE  = MAX_SRC_SIDE_DEF,
    parameter int unsigned OUT_WIDTH     = OUT_WIDTH_DEF,
    parameter int unsigned OUT_HEIGHT    = OUT_HEIGHT_DEF,
    parameter int unsigned SEARCH_RADIUS = SEARCH_RADIUS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_req_type,
    input  logic [7:0]        i_col,
    input  logic [7:0]        i_row,
    input  logic [7:0]        i_pixel_value,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_distance_code,
    output logic              o_source_inside,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    localparam int unsigned WW      = $clog2(MAX_SRC_SIDE + 1);
    localparam int unsigned XW      = $clog2(MAX_SRC_SIDE);
    localparam int unsigned LCW_RAW = $clog2(MAX_SRC_SIDE + 1) - 1;
    localparam int unsigned LCW     = (LCW_RAW > CHUNK_MAX_LOG) ? CHUNK_MAX_LOG : LCW_RAW;
    localparam int unsigned CW      = 1 << LCW;
    localparam int unsigned NCH     = (MAX_SRC_SIDE + CW - 1) / CW;
    localparam int unsigned CHW     = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int unsigned DEPTH   = MAX_SRC_SIDE * NCH;
    localparam int unsigned AW      = $clog2(DEPTH);
    localparam int unsigned IW      = ((CHW + LCW) > WW) ? (CHW + LCW) : WW;
    localparam int unsigned HALF    = SEARCH_RADIUS / 2;
    localparam int unsigned CAP     = HALF * HALF;
    localparam int unsigned CAPW    = $clog2(CAP + 1);
    localparam int unsigned SW      = ((2 * IW + 1) > CAPW) ? (2 * IW + 1) : CAPW;
    localparam int unsigned PW      = ((SW + 16) > TW) ? (SW + 16) : TW;
    localparam int unsigned NW      = 8 + WW;
    localparam int unsigned BW      = $clog2(KW);
    localparam t_thr_tab    THR     = thr_table(SEARCH_RADIUS);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_WRD   = 4'd1;
    localparam logic [3:0] ST_WWR   = 4'd2;
    localparam logic [3:0] ST_DST   = 4'd3;
    localparam logic [3:0] ST_DIV   = 4'd4;
    localparam logic [3:0] ST_CEN   = 4'd5;
    localparam logic [3:0] ST_CENW  = 4'd6;
    localparam logic [3:0] ST_SCAN  = 4'd7;
    localparam logic [3:0] ST_DRAIN = 4'd8;
    localparam logic [3:0] ST_MUL   = 4'd9;
    localparam logic [3:0] ST_SRCH  = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    logic [3:0]        r_st;
    logic [CFG_DW-1:0] r_w;
    logic [CFG_DW-1:0] r_h;
    logic [7:0]        r_thr;
    logic [7:0]        r_q_col;
    logic [7:0]        r_q_row;
    logic              r_q_bit;
    logic              r_wr_ok;
    logic [XW-1:0]     r_cx;
    logic [XW-1:0]     r_cy;
    logic              r_src_in;
    logic [WW-1:0]     r_ar;
    logic [CHW-1:0]    r_ac;
    logic              r_t1_v;
    logic [WW-1:0]     r_t1_row;
    logic [CHW-1:0]    r_t1_ch;
    logic              r_t1_last;
    logic              r_b_v;
    logic              r_b_f;
    logic [IW-1:0]     r_b_dx;
    logic [WW-1:0]     r_b_row;
    logic              r_b_last;
    logic              r_acc_f;
    logic [IW-1:0]     r_acc_dx;
    logic              r_c_v;
    logic              r_c_f;
    logic [IW-1:0]     r_c_dx;
    logic [WW-1:0]     r_c_row;
    logic              r_d_v;
    logic              r_d_f;
    logic [2*IW-1:0]   r_d_dx2;
    logic [2*IW-1:0]   r_d_dy2;
    logic [SW-1:0]     r_best;
    logic [PW-1:0]     r_prod;
    logic [KW-1:0]     r_k;
    logic [BW-1:0]     r_bit;
    logic              r_ov;
    logic [7:0]        r_oc;
    logic              r_oi;

    logic [WW-1:0]     w_eff;
    logic [WW-1:0]     h_eff;
    logic              in_acc;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CW-1:0]     ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CW-1:0]     ram_rdata;
    logic              div_start;
    logic              div_x_done;
    logic              div_y_done;
    logic [NW-1:0]     div_x_quo;
    logic [NW-1:0]     div_y_quo;
    logic [NW-1:0]     div_x_num;
    logic [NW-1:0]     div_y_num;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     cen_addr;
    logic [AW-1:0]     scan_addr;
    logic [IW-1:0]     tr_v [1:2*CW-1];
    logic              tr_f [1:2*CW-1];
    logic [IW-1:0]     lane_ix;
    logic [IW-1:0]     cx_ext;
    logic              m_f;
    logic [IW-1:0]     m_dx;
    logic [IW-1:0]     dy_abs;
    logic [SW-1:0]     d_sum;
    logic [KW-1:0]     cand;
    logic [XW-1:0]     cx_sat;
    logic [XW-1:0]     cy_sat;
    logic              pipe_busy;

    // zero acts as one, oversize acts as the store side
    always_comb begin
        if (r_w == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_w) > MAX_SRC_SIDE) begin
            w_eff = WW'(MAX_SRC_SIDE);
        end else begin
            w_eff = WW'(r_w);
        end
        if (r_h == '0) begin
            h_eff = WW'(1);
        end else if (32'(r_h) > MAX_SRC_SIDE) begin
            h_eff = WW'(MAX_SRC_SIDE);
        end else begin
            h_eff = WW'(r_h);
        end
    end

    assign in_acc      = i_valid && !o_stall;
    assign o_stall     = (r_st != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign wr_addr   = AW'(32'(r_q_row) * NCH + (32'(r_q_col) >> LCW));
    assign cen_addr  = AW'(32'(r_cy) * NCH + (32'(r_cx) >> LCW));
    assign scan_addr = AW'(32'(r_ar) * NCH + 32'(r_ac));

    always_comb begin
        case (r_st)
            ST_WRD:  ram_raddr = wr_addr;
            ST_CEN:  ram_raddr = cen_addr;
            ST_SCAN: ram_raddr = scan_addr;
            default: ram_raddr = scan_addr;
        endcase
    end

    always_comb begin
        ram_wdata                         = ram_rdata;
        ram_wdata[r_q_col[LCW-1:0]]       = r_q_bit;
    end
    assign ram_we    = (r_st == ST_WWR) && r_wr_ok;
    assign ram_waddr = wr_addr;

    sdfs_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH)
    ) u_mask (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // source coordinate = out * side / out_size
    assign div_start = (r_st == ST_DST);
    assign div_x_num = NW'(r_q_col) * NW'(w_eff);
    assign div_y_num = NW'(r_q_row) * NW'(h_eff);

    sdfs_div #(
        .NW  (NW),
        .DEN (OUT_WIDTH)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_x_num),
        .o_done  (div_x_done),
        .o_quo   (div_x_quo)
    );

    sdfs_div #(
        .NW  (NW),
        .DEN (OUT_HEIGHT)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_y_num),
        .o_done  (div_y_done),
        .o_quo   (div_y_quo)
    );

    assign cx_sat = (div_x_quo > NW'(w_eff - WW'(1))) ? XW'(w_eff - WW'(1)) : XW'(div_x_quo);
    assign cy_sat = (div_y_quo > NW'(h_eff - WW'(1))) ? XW'(h_eff - WW'(1)) : XW'(div_y_quo);

    // nearest opposite-class column within one mask word, as a min tree
    assign cx_ext = IW'(r_cx);
    always_comb begin
        for (int l = 0; l < CW; l++) begin
            lane_ix     = IW'({r_t1_ch, LCW'(l)});
            tr_f[CW+l]  = (ram_rdata[l] != r_src_in) && (lane_ix < IW'(w_eff));
            tr_v[CW+l]  = (lane_ix >= cx_ext) ? (lane_ix - cx_ext) : (cx_ext - lane_ix);
        end
        for (int i = CW - 1; i >= 1; i--) begin
            tr_f[i] = tr_f[2*i] || tr_f[2*i+1];
            if (tr_f[2*i] && (!tr_f[2*i+1] || (tr_v[2*i] <= tr_v[2*i+1]))) begin
                tr_v[i] = tr_v[2*i];
            end else begin
                tr_v[i] = tr_v[2*i+1];
            end
        end
    end

    // merge the word minimum into the row minimum
    always_comb begin
        m_f  = r_acc_f || r_b_f;
        m_dx = r_acc_dx;
        if (r_b_f && (!r_acc_f || (r_b_dx < r_acc_dx))) begin
            m_dx = r_b_dx;
        end
    end

    assign dy_abs    = (IW'(r_c_row) >= IW'(r_cy)) ? (IW'(r_c_row) - IW'(r_cy))
                                                   : (IW'(r_cy) - IW'(r_c_row));
    assign d_sum     = SW'(r_d_dx2) + SW'(r_d_dy2);
    assign cand      = r_k | (KW'(1) << r_bit);
    assign pipe_busy = r_t1_v || r_b_v || r_c_v || r_d_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_w     <= CFG_DW'(256);
            r_h     <= CFG_DW'(256);
            r_thr   <= 8'd128;
            r_t1_v  <= 1'b0;
            r_b_v   <= 1'b0;
            r_c_v   <= 1'b0;
            r_d_v   <= 1'b0;
            r_ov    <= 1'b0;
            r_acc_f <= 1'b0;
            r_best  <= SW'(CAP);
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SRC_WIDTH:  r_w   <= i_cfg_data;
                    CFG_SRC_HEIGHT: r_h   <= i_cfg_data;
                    CFG_THRESHOLD:  r_thr <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end

            // scan pipeline: read tag, word minimum, row minimum, squares, best
            r_t1_v <= 1'b0;
            r_b_v  <= r_t1_v;
            if (r_t1_v) begin
                r_b_f    <= tr_f[1];
                r_b_dx   <= tr_v[1];
                r_b_row  <= r_t1_row;
                r_b_last <= r_t1_last;
            end
            r_c_v <= r_b_v && r_b_last;
            if (r_b_v) begin
                if (r_b_last) begin
                    r_c_f    <= m_f;
                    r_c_dx   <= m_dx;
                    r_c_row  <= r_b_row;
                    r_acc_f  <= 1'b0;
                end else begin
                    r_acc_f  <= m_f;
                    r_acc_dx <= m_dx;
                end
            end
            r_d_v <= r_c_v;
            if (r_c_v) begin
                r_d_f   <= r_c_f;
                r_d_dx2 <= (2*IW)'(r_c_dx) * (2*IW)'(r_c_dx);
                r_d_dy2 <= (2*IW)'(dy_abs) * (2*IW)'(dy_abs);
            end
            if (r_d_v && r_d_f && (d_sum < r_best)) begin
                r_best <= d_sum;
            end

            case (r_st)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_q_col <= i_col;
                        r_q_row <= i_row;
                        r_q_bit <= i_pixel_value > r_thr;
                        r_wr_ok <= (32'(i_col) < MAX_SRC_SIDE) && (32'(i_row) < MAX_SRC_SIDE);
                        r_st    <= i_req_type ? ST_DST : ST_WRD;
                    end
                end
                ST_WRD:  r_st <= ST_WWR;
                ST_WWR:  r_st <= ST_IDLE;
                ST_DST:  r_st <= ST_DIV;
                ST_DIV: begin
                    if (div_x_done && div_y_done) begin
                        r_cx <= cx_sat;
                        r_cy <= cy_sat;
                        r_st <= ST_CEN;
                    end
                end
                ST_CEN:  r_st <= ST_CENW;
                ST_CENW: begin
                    r_src_in <= ram_rdata[r_cx[LCW-1:0]];
                    r_ar     <= '0;
                    r_ac     <= '0;
                    r_acc_f  <= 1'b0;
                    r_best   <= SW'(CAP);
                    r_st     <= ST_SCAN;
                end
                ST_SCAN: begin
                    r_t1_v    <= 1'b1;
                    r_t1_row  <= r_ar;
                    r_t1_ch   <= r_ac;
                    r_t1_last <= (r_ac == CHW'(NCH - 1));
                    if (r_ac == CHW'(NCH - 1)) begin
                        r_ac <= '0;
                        r_ar <= r_ar + WW'(1);
                        if (r_ar == h_eff - WW'(1)) begin
                            r_st <= ST_DRAIN;
                        end
                    end else begin
                        r_ac <= r_ac + CHW'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!pipe_busy) begin
                        r_st <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_prod <= PW'(r_best) * PW'(CODE_SCALE_SQ);
                    r_k    <= '0;
                    r_bit  <= BW'(KW - 1);
                    r_st   <= ST_SRCH;
                end
                ST_SRCH: begin
                    if (PW'(THR[cand]) <= r_prod) begin
                        r_k <= cand;
                    end
                    if (r_bit == '0) begin
                        r_st <= ST_OUT;
                    end else begin
                        r_bit <= r_bit - BW'(1);
                    end
                end
                ST_OUT: begin
                    if (!r_ov) begin
                        r_ov <= 1'b1;
                        r_oc <= {r_src_in, r_k};
                        r_oi <= r_src_in;
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_valid         = r_ov;
    assign o_distance_code = r_oc;
    assign o_source_inside = r_oi;

    `SDFS_ASSERT_NOW(a_scan_row, r_st == ST_SCAN, r_ar < h_eff, "scan row beyond image height")
    `SDFS_ASSERT_NOW(a_best_cap, r_st != ST_IDLE, r_best <= SW'(CAP), "best distance above cap")
    `SDFS_ASSERT_NEXT(a_query_go, in_acc && i_req_type, r_st == ST_DST, "query transaction not started")
    `SDFS_ASSERT_NOW(a_code_msb, o_valid, o_distance_code[7] == o_source_inside, "code and inside flag disagree")

endmodule
